### hdl/cfd_pkg.sv
// Package for the CRC-16 checked frame deframer.
// Holds frame constants, status and phase codes, the result struct and the CRC byte update.
// No dependencies.
`default_nettype none

package cfd_pkg;

	localparam logic [7:0]  HDR_FIRST     = 8'hAA;
	localparam logic [7:0]  HDR_SECOND    = 8'h55;
	localparam logic [7:0]  SKIP_CMD      = 8'hFF;
	localparam logic [7:0]  SKIP_LAST_IDX = 8'd6;
	localparam logic [7:0]  CMD_IDX       = 8'd3;
	localparam logic [7:0]  MIN_LENGTH    = 8'd4;
	localparam logic [15:0] CRC_INIT      = 16'hFFFF;
	localparam logic [15:0] CRC_POLY      = 16'hA001;

	// Status carried on each delivered byte
	typedef enum logic [1:0] {
		ST_RUN  = 2'd0,
		ST_GOOD = 2'd1,
		ST_BAD  = 2'd2,
		ST_SKIP = 2'd3
	} status_t;

	// Deframer phase, one-hot
	typedef enum logic [5:0] {
		PH_HUNT   = 6'b000001,
		PH_WANT55 = 6'b000010,
		PH_LEN    = 6'b000100,
		PH_BODY   = 6'b001000,
		PH_CRCLO  = 6'b010000,
		PH_CRCHI  = 6'b100000
	} phase_t;

	// One parse result, valid when emit is set
	typedef struct packed {
		logic       emit;
		logic [7:0] data;
		logic       first;
		logic       last;
		status_t    status;
	} res_t;

	// CRC-16/Modbus update by one byte, reflected, LSB first
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

### hdl/crc16_checked_frame_deframer.sv
// Channel | handshake            | payload
// input   | in_valid / in_stall  | rx_byte
// output  | out_valid / out_stall| frame_byte, first_byte, last_byte, frame_status
//
// One item per cycle sustained while out_stall is low. A byte is held in the
// input register, parsed and CRC-updated by combinational logic, and lands in the
// result register; emitted results raise out_valid. Reset clears valid flags and
// frame state (hunting for header, CRC 0xFFFF). Output stall holds the result
// register and, through it, the input register; bytes that make no result wait too.
// Top level: input register, parser and result register.
// Depends on cfd_pkg, cfd_in_reg and cfd_parser.
`default_nettype none

module crc16_checked_frame_deframer
	import cfd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] rx_byte,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      frame_byte,
	output logic            first_byte,
	output logic            last_byte,
	output logic [1:0]      frame_status
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       out_free;
	logic       adv;
	res_t       res;
	logic       out_valid_q;
	logic [7:0] frame_byte_q;
	logic       first_q;
	logic       last_q;
	status_t    status_q;

	// The held item moves on whenever the result register can take a result
	assign out_free = !out_valid_q || !out_stall;
	assign adv      = valid_s1 && out_free;

	cfd_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.rx_byte  (rx_byte),
		.adv      (adv),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	cfd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.byte_s1 (byte_s1),
		.res     (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= adv && res.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res.emit) begin
			frame_byte_q <= res.data;
			first_q      <= res.first;
			last_q       <= res.last;
			status_q     <= res.status;
		end
	end

	assign out_valid    = out_valid_q;
	assign frame_byte   = frame_byte_q;
	assign first_byte   = first_q;
	assign last_byte    = last_q;
	assign frame_status = status_q;

endmodule

`default_nettype wire

### hdl/cfd_in_reg.sv
// Input register for the deframer: holds one received byte for the parse stage.
// Depends on nothing but the clock and reset.
`default_nettype none

module cfd_in_reg (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] rx_byte,
	input  wire logic       adv,
	output logic            valid_s1,
	output logic [7:0]      byte_s1
);

	// Stall only when the held item cannot move on this cycle
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

endmodule

`default_nettype wire

### hdl/cfd_parser.sv
// Frame parser: header hunt, length, body, CRC check and skip-frame handling.
// Depends on cfd_pkg for codes, the result struct and the CRC update.
`default_nettype none

module cfd_parser
	import cfd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       adv,
	input  wire logic [7:0] byte_s1,
	output res_t            res
);

	phase_t      phase_q, phase_d;
	logic [7:0]  idx_q, idx_d;
	logic [7:0]  len_q, len_d;
	logic [15:0] crc_q, crc_d;
	logic [7:0]  crc_lo_q, crc_lo_d;
	logic        skip_q, skip_d;

	logic [15:0] crc_next;
	logic        skip_now;
	logic [8:0]  idx_inc;

	assign crc_next = crc16_byte(crc_q, byte_s1);
	assign skip_now = skip_q || (idx_q == CMD_IDX && byte_s1 == SKIP_CMD);
	assign idx_inc  = {1'b0, idx_q} + 9'd1;

	// Next state and result for the held byte
	always_comb begin
		phase_d    = phase_q;
		idx_d      = idx_q;
		len_d      = len_q;
		crc_d      = crc_q;
		crc_lo_d   = crc_lo_q;
		skip_d     = skip_q;
		res.emit   = 1'b0;
		res.data   = byte_s1;
		res.first  = 1'b0;
		res.last   = 1'b0;
		res.status = ST_RUN;
		unique case (phase_q)
			PH_WANT55: begin
				if (byte_s1 == HDR_SECOND) begin
					crc_d    = crc_next;
					phase_d  = PH_LEN;
					res.emit = 1'b1;
				end else if (byte_s1 == HDR_FIRST) begin
					crc_d     = crc16_byte(CRC_INIT, HDR_FIRST);
					skip_d    = 1'b0;
					idx_d     = 8'd0;
					phase_d   = PH_WANT55;
					res.emit  = 1'b1;
					res.first = 1'b1;
				end else begin
					phase_d = PH_HUNT;
				end
			end
			PH_LEN: begin
				if (byte_s1 < MIN_LENGTH) begin
					phase_d = PH_HUNT;
				end else begin
					len_d    = byte_s1;
					crc_d    = crc_next;
					idx_d    = CMD_IDX;
					phase_d  = PH_BODY;
					res.emit = 1'b1;
				end
			end
			PH_BODY: begin
				crc_d    = crc_next;
				res.emit = 1'b1;
				if (skip_now) begin
					if (idx_q >= SKIP_LAST_IDX) begin
						phase_d    = PH_HUNT;
						skip_d     = 1'b0;
						res.last   = 1'b1;
						res.status = ST_SKIP;
					end else begin
						skip_d = 1'b1;
						idx_d  = idx_inc[7:0];
					end
				end else begin
					if (idx_inc >= {1'b0, len_q}) begin
						phase_d = PH_CRCLO;
					end
					idx_d = idx_inc[7:0];
				end
			end
			PH_CRCLO: begin
				crc_lo_d = byte_s1;
				phase_d  = PH_CRCHI;
				res.emit = 1'b1;
			end
			PH_CRCHI: begin
				phase_d    = PH_HUNT;
				res.emit   = 1'b1;
				res.last   = 1'b1;
				res.status = ({byte_s1, crc_lo_q} == crc_q) ? ST_GOOD : ST_BAD;
			end
			default: begin
				// Hunt, and any stray phase code
				if (byte_s1 == HDR_FIRST) begin
					crc_d     = crc16_byte(CRC_INIT, HDR_FIRST);
					skip_d    = 1'b0;
					idx_d     = 8'd0;
					phase_d   = PH_WANT55;
					res.emit  = 1'b1;
					res.first = 1'b1;
				end else begin
					phase_d = PH_HUNT;
				end
			end
		endcase
	end

	// Frame state advances once per consumed item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			idx_q    <= 8'd0;
			len_q    <= 8'd0;
			crc_q    <= CRC_INIT;
			crc_lo_q <= 8'd0;
			skip_q   <= 1'b0;
		end else if (adv) begin
			phase_q  <= phase_d;
			idx_q    <= idx_d;
			len_q    <= len_d;
			crc_q    <= crc_d;
			crc_lo_q <= crc_lo_d;
			skip_q   <= skip_d;
		end
	end

endmodule

`default_nettype wire

### hdl/cfd_checker.sv
// Port-level checks for the deframer, bound to the top level.
// Depends on cfd_pkg for header and status codes.
`default_nettype none

module cfd_checker
	import cfd_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [7:0] frame_byte,
	input wire logic       first_byte,
	input wire logic       last_byte,
	input wire logic [1:0] frame_status
);

	// Final byte always carries a finished status
	a_last_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_byte |-> frame_status != ST_RUN)
		else $error("last item without a final status");

	// Every other byte is in progress
	a_run_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_byte |-> frame_status == ST_RUN)
		else $error("final status on a non-last item");

	// Frame opener is the header byte and never the end
	a_first_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && first_byte |-> frame_byte == HDR_FIRST && !last_byte)
		else $error("first item is not an open header byte");

	// Stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(frame_byte))
		else $error("stalled result changed");

endmodule

bind crc16_checked_frame_deframer cfd_checker u_cfd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.frame_byte   (frame_byte),
	.first_byte   (first_byte),
	.last_byte    (last_byte),
	.frame_status (frame_status)
);

`default_nettype wire
